// ===== sv/csvt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the cross-venue spread tracker.
// Used by the channel interfaces and the top level.

package csvt_pkg;

    localparam int TS_W        = 63;
    localparam int PRICE_F_W   = 62;
    localparam int SPREAD_W    = 48;
    localparam int PEN_W       = 47;
    localparam int FEE_W       = 32;
    localparam int GAP_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int BPS_W       = 14;

    localparam logic [BPS_W-1:0]      BPS_SCALE   = 14'd10000;
    localparam logic [GAP_W-1:0]      STALE_RESET = 32'd1000000000;
    localparam logic [SPREAD_W-1:0]   SAT_POS     = {1'b0, {(SPREAD_W-1){1'b1}}};
    localparam logic [SPREAD_W-1:0]   SAT_NEG     = {1'b1, {(SPREAD_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0]  CFG_STALE_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_FEE       = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_UPD,
        S_CHK,
        S_CLOSE,
        S_SUMS,
        S_MAGS,
        S_MULA,
        S_WMA,
        S_MULB,
        S_WMB,
        S_PICK,
        S_RAW,
        S_MULK,
        S_WMK,
        S_DIVK,
        S_WDK,
        S_SATK,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        TERM_RAW,
        TERM_PEN,
        TERM_NET
    } t_term;

endpackage

// ===== sv/csvt_quote_if.sv =====
`timescale 1ns / 1ps
// Channel that carries one quote word into the spread tracker.
// Depends on csvt_pkg for field widths.

interface csvt_quote_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [csvt_pkg::TS_W-1:0]        ts_ns;
    logic [csvt_pkg::PRICE_F_W-1:0]   bid_price;
    logic [csvt_pkg::PRICE_F_W-1:0]   ask_price;

    modport source (output valid, action, ts_ns, bid_price, ask_price, input ready);
    modport sink   (input valid, action, ts_ns, bid_price, ask_price, output ready);
endinterface

// ===== sv/csvt_point_if.sv =====
`timescale 1ns / 1ps
// Channel that carries one spread point word out of the spread tracker.
// Depends on csvt_pkg for field widths.

interface csvt_point_if;
    logic                                  valid;
    logic                                  ready;
    logic [csvt_pkg::TS_W-1:0]             point_time;
    logic signed [csvt_pkg::SPREAD_W-1:0]  raw_spread;
    logic [csvt_pkg::PEN_W-1:0]            internal_penalty;
    logic signed [csvt_pkg::FEE_W-1:0]     fee_out;
    logic signed [csvt_pkg::SPREAD_W-1:0]  net_spread;
    logic                                  direction;
    logic [csvt_pkg::PRICE_F_W-1:0]        buy_price;
    logic [csvt_pkg::PRICE_F_W-1:0]        sell_price;

    modport source (output valid, point_time, raw_spread, internal_penalty, fee_out,
                    net_spread, direction, buy_price, sell_price, input ready);
    modport sink   (input valid, point_time, raw_spread, internal_penalty, fee_out,
                    net_spread, direction, buy_price, sell_price, output ready);
endinterface

// ===== sv/csvt_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; used by the spread tracker top level.

module csvt_mul #(
    parameter int W = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic             o_done,
    output logic [2*W-1:0]   o_prod
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_low;
    logic [W:0]       w_sum;

    assign w_sum = {1'b0, r_acc} + (r_low[0] ? {1'b0, r_a} : {(W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= i_a;
                r_acc <= '0;
                r_low <= i_b;
                r_cnt <= CNT_W'(W);
            end else if (r_cnt != '0) begin
                r_acc  <= w_sum[W:1];
                r_low  <= {w_sum[0], r_low[W-1:1]};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_acc, r_low};

endmodule

// ===== sv/csvt_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the spread tracker top level.

module csvt_div #(
    parameter int NUM_W = 94,
    parameter int DEN_W = 62
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_nq;
    logic [DEN_W:0]   w_t;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_t    = {r_rem, r_nq[NUM_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_den});
    assign w_diff = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= '0;
                r_den <= i_den;
                r_nq  <= i_num;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
                r_nq   <= {r_nq[NUM_W-2:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

// ===== sv/cross_venue_spread_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the cross-venue spread tracker: sequencer, quote store and result register.
// Depends on csvt_pkg, csvt_quote_if, csvt_point_if, csvt_mul and csvt_div.
//
//   Channel    Dir   Handshake      Word
//   i_quote    in    valid/ready    action, ts_ns, bid_price, ask_price
//   o_point    out   valid/ready    point_time, spreads, penalty, fee, direction, prices
//   i_cfg_*    in    write enable   register index and 32-bit data
//
// The sequencer takes one quote at a time and is ready for a new one only when idle.
// Its run time is set by the bit-serial multiplier and the radix-2 divider that every
// term goes through. An item that produces no point returns to idle after the update
// and check states, without using either unit.
// Reset is synchronous and active low; it drops both held quotes and restores the registers.
// A finished point waits in the output register while the next quote is taken in.

module cross_venue_spread_tracker #(
    parameter int FRAC_BITS   = 16,
    parameter int PRICE_WIDTH = 62
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    csvt_quote_if.sink                        i_quote,
    csvt_point_if.source                      o_point,
    input  logic                              i_cfg_we,
    input  logic [csvt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [csvt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PW     = PRICE_WIDTH;
    localparam int MAG_W  = PW + 2;
    localparam int PROD_W = 2 * MAG_W;
    localparam int NUMP_W = MAG_W + csvt_pkg::BPS_W;
    localparam int NUM_W  = NUMP_W + FRAC_BITS;
    localparam int TS_W   = csvt_pkg::TS_W;
    localparam int SP_W   = csvt_pkg::SPREAD_W;

    csvt_pkg::t_state r_state, n_state;
    csvt_pkg::t_term  r_term;

    logic                           r_venue;
    logic [TS_W-1:0]                r_ts;
    logic [PW-1:0]                  r_bid, r_ask;
    logic                           r_held_a, r_held_b;
    logic [TS_W-1:0]                r_qt_a, r_qt_b;
    logic [PW-1:0]                  r_bid_a, r_ask_a, r_bid_b, r_ask_b;
    logic [csvt_pkg::GAP_W-1:0]     r_gap;
    logic [csvt_pkg::FEE_W-1:0]     r_fee;
    logic [PW-1:0]                  r_sa, r_sb;
    logic [PW:0]                    r_close;
    logic [MAG_W-1:0]               r_tot_a, r_tot_b;
    logic [MAG_W-1:0]               r_mag_a, r_mag_b;
    logic                           r_neg_a, r_neg_b;
    logic [PROD_W-1:0]              r_pa, r_pb;
    logic                           r_dir;
    logic [PW-1:0]                  r_buy, r_sell;
    logic [PW-1:0]                  r_rmag;
    logic                           r_rneg;
    logic [MAG_W-1:0]               r_nmag;
    logic                           r_nneg;
    logic [NUMP_W-1:0]              r_num;
    logic [NUM_W-1:0]               r_q;
    logic [SP_W-1:0]                r_raw, r_net;
    logic [csvt_pkg::PEN_W-1:0]     r_pen;

    logic                           r_o_valid;
    logic [TS_W-1:0]                r_o_time;
    logic [SP_W-1:0]                r_o_raw, r_o_net;
    logic [csvt_pkg::PEN_W-1:0]     r_o_pen;
    logic [csvt_pkg::FEE_W-1:0]     r_o_fee;
    logic                           r_o_dir;
    logic [PW-1:0]                  r_o_buy, r_o_sell;

    logic                           w_accept;
    logic                           w_out_go;
    logic                           w_mul_start, w_mul_done;
    logic [MAG_W-1:0]               w_mul_a, w_mul_b;
    logic [PROD_W-1:0]              w_prod;
    logic                           w_div_start, w_div_done;
    logic [NUM_W-1:0]               w_quot;
    logic [MAG_W-1:0]               w_term_mag;
    logic                           w_term_neg;
    logic [TS_W:0]                  w_age_a, w_age_b;
    logic                           w_fresh_a, w_fresh_b;
    logic                           w_quote_ok;
    logic [MAG_W:0]                 w_da, w_db;
    logic [PW:0]                    w_dr;
    logic                           w_na, w_nb, w_gt, w_eq, w_pick_a;
    logic                           w_big_pos, w_big_neg;
    logic [SP_W-1:0]                w_pos_val, w_neg_val;

    assign w_accept = i_quote.valid && i_quote.ready;
    assign w_out_go = !r_o_valid || o_point.ready;
    assign i_quote.ready = (r_state == csvt_pkg::S_IDLE);

    csvt_mul #(.W(MAG_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    csvt_div #(.NUM_W(NUM_W), .DEN_W(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_num, {FRAC_BITS{1'b0}}}),
        .i_den   (r_buy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        case (r_term)
            csvt_pkg::TERM_RAW: begin
                w_term_mag = MAG_W'(r_rmag);
                w_term_neg = r_rneg;
            end
            csvt_pkg::TERM_PEN: begin
                w_term_mag = MAG_W'(r_close);
                w_term_neg = 1'b0;
            end
            csvt_pkg::TERM_NET: begin
                w_term_mag = r_nmag;
                w_term_neg = r_nneg;
            end
            default: begin
                w_term_mag = '0;
                w_term_neg = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            csvt_pkg::S_MULA: begin
                w_mul_a = r_mag_a;
                w_mul_b = MAG_W'(r_ask_b);
            end
            csvt_pkg::S_MULB: begin
                w_mul_a = r_mag_b;
                w_mul_b = MAG_W'(r_ask_a);
            end
            default: begin
                w_mul_a = w_term_mag;
                w_mul_b = MAG_W'(csvt_pkg::BPS_SCALE);
            end
        endcase
    end

    assign w_quote_ok = (r_bid != '0) && (r_ask != '0) && (r_ask >= r_bid);
    assign w_age_a    = {1'b0, r_ts} - {1'b0, r_qt_a};
    assign w_age_b    = {1'b0, r_ts} - {1'b0, r_qt_b};
    assign w_fresh_a  = !w_age_a[TS_W] && (w_age_a[TS_W-1:0] <= TS_W'(r_gap));
    assign w_fresh_b  = !w_age_b[TS_W] && (w_age_b[TS_W-1:0] <= TS_W'(r_gap));

    assign w_da = (MAG_W+1)'(r_bid_b) - {1'b0, r_tot_a};
    assign w_db = (MAG_W+1)'(r_bid_a) - {1'b0, r_tot_b};
    assign w_dr = {1'b0, r_sell} - {1'b0, r_buy};

    assign w_na     = r_neg_a && (r_pa != '0);
    assign w_nb     = r_neg_b && (r_pb != '0);
    assign w_gt     = (r_pa > r_pb);
    assign w_eq     = (r_pa == r_pb);
    assign w_pick_a = (!w_na && w_nb) || (!w_na && !w_nb && (w_gt || w_eq))
                      || (w_na && w_nb && !w_gt);

    assign w_big_pos = |r_q[NUM_W-1:SP_W-1];
    assign w_big_neg = (|r_q[NUM_W-1:SP_W]) || (r_q[SP_W-1] && (|r_q[SP_W-2:0]));
    assign w_pos_val = w_big_pos ? csvt_pkg::SAT_POS : {1'b0, r_q[SP_W-2:0]};
    assign w_neg_val = w_big_neg ? csvt_pkg::SAT_NEG : ({SP_W{1'b0}} - r_q[SP_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csvt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            csvt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = csvt_pkg::S_UPD;
                end
            end
            csvt_pkg::S_UPD: begin
                n_state = csvt_pkg::S_CHK;
            end
            csvt_pkg::S_CHK: begin
                if (r_held_a && r_held_b && w_fresh_a && w_fresh_b) begin
                    n_state = csvt_pkg::S_CLOSE;
                end else begin
                    n_state = csvt_pkg::S_IDLE;
                end
            end
            csvt_pkg::S_CLOSE: begin
                n_state = csvt_pkg::S_SUMS;
            end
            csvt_pkg::S_SUMS: begin
                n_state = csvt_pkg::S_MAGS;
            end
            csvt_pkg::S_MAGS: begin
                n_state = csvt_pkg::S_MULA;
            end
            csvt_pkg::S_MULA: begin
                w_mul_start = 1'b1;
                n_state     = csvt_pkg::S_WMA;
            end
            csvt_pkg::S_WMA: begin
                if (w_mul_done) begin
                    n_state = csvt_pkg::S_MULB;
                end
            end
            csvt_pkg::S_MULB: begin
                w_mul_start = 1'b1;
                n_state     = csvt_pkg::S_WMB;
            end
            csvt_pkg::S_WMB: begin
                if (w_mul_done) begin
                    n_state = csvt_pkg::S_PICK;
                end
            end
            csvt_pkg::S_PICK: begin
                n_state = csvt_pkg::S_RAW;
            end
            csvt_pkg::S_RAW: begin
                n_state = csvt_pkg::S_MULK;
            end
            csvt_pkg::S_MULK: begin
                w_mul_start = 1'b1;
                n_state     = csvt_pkg::S_WMK;
            end
            csvt_pkg::S_WMK: begin
                if (w_mul_done) begin
                    n_state = csvt_pkg::S_DIVK;
                end
            end
            csvt_pkg::S_DIVK: begin
                w_div_start = 1'b1;
                n_state     = csvt_pkg::S_WDK;
            end
            csvt_pkg::S_WDK: begin
                if (w_div_done) begin
                    n_state = csvt_pkg::S_SATK;
                end
            end
            csvt_pkg::S_SATK: begin
                if (r_term == csvt_pkg::TERM_NET) begin
                    n_state = csvt_pkg::S_OUT;
                end else begin
                    n_state = csvt_pkg::S_MULK;
                end
            end
            csvt_pkg::S_OUT: begin
                if (w_out_go) begin
                    n_state = csvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csvt_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration registers and held-quote flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap    <= csvt_pkg::STALE_RESET;
            r_fee    <= '0;
            r_held_a <= 1'b0;
            r_held_b <= 1'b0;
            r_qt_a   <= '0;
            r_qt_b   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csvt_pkg::CFG_STALE_GAP: r_gap <= i_cfg_data;
                    csvt_pkg::CFG_FEE:       r_fee <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == csvt_pkg::S_UPD && w_quote_ok) begin
                if (r_venue) begin
                    r_held_b <= 1'b1;
                    r_qt_b   <= r_ts;
                end else begin
                    r_held_a <= 1'b1;
                    r_qt_a   <= r_ts;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_venue <= i_quote.action;
            r_ts    <= i_quote.ts_ns;
            r_bid   <= i_quote.bid_price[PW-1:0];
            r_ask   <= i_quote.ask_price[PW-1:0];
        end
        case (r_state)
            csvt_pkg::S_UPD: begin
                if (w_quote_ok) begin
                    if (r_venue) begin
                        r_bid_b <= r_bid;
                        r_ask_b <= r_ask;
                    end else begin
                        r_bid_a <= r_bid;
                        r_ask_a <= r_ask;
                    end
                end
            end
            csvt_pkg::S_CHK: begin
                r_sa <= r_ask_a - r_bid_a;
                r_sb <= r_ask_b - r_bid_b;
            end
            csvt_pkg::S_CLOSE: begin
                r_close <= {1'b0, r_sa} + {1'b0, r_sb};
            end
            csvt_pkg::S_SUMS: begin
                r_tot_a <= MAG_W'(r_ask_a) + MAG_W'(r_close);
                r_tot_b <= MAG_W'(r_ask_b) + MAG_W'(r_close);
            end
            csvt_pkg::S_MAGS: begin
                r_neg_a <= w_da[MAG_W];
                r_neg_b <= w_db[MAG_W];
                r_mag_a <= w_da[MAG_W] ? MAG_W'(-w_da) : w_da[MAG_W-1:0];
                r_mag_b <= w_db[MAG_W] ? MAG_W'(-w_db) : w_db[MAG_W-1:0];
            end
            csvt_pkg::S_WMA: begin
                if (w_mul_done) begin
                    r_pa <= w_prod;
                end
            end
            csvt_pkg::S_WMB: begin
                if (w_mul_done) begin
                    r_pb <= w_prod;
                end
            end
            csvt_pkg::S_PICK: begin
                r_dir  <= !w_pick_a;
                r_buy  <= w_pick_a ? r_ask_a : r_ask_b;
                r_sell <= w_pick_a ? r_bid_b : r_bid_a;
                r_nmag <= w_pick_a ? r_mag_a : r_mag_b;
                r_nneg <= w_pick_a ? r_neg_a : r_neg_b;
            end
            csvt_pkg::S_RAW: begin
                r_rneg <= w_dr[PW];
                r_rmag <= w_dr[PW] ? PW'(-w_dr) : w_dr[PW-1:0];
                r_term <= csvt_pkg::TERM_RAW;
            end
            csvt_pkg::S_WMK: begin
                if (w_mul_done) begin
                    r_num <= w_prod[NUMP_W-1:0];
                end
            end
            csvt_pkg::S_WDK: begin
                if (w_div_done) begin
                    r_q <= w_quot;
                end
            end
            csvt_pkg::S_SATK: begin
                case (r_term)
                    csvt_pkg::TERM_RAW: begin
                        r_raw  <= w_term_neg ? w_neg_val : w_pos_val;
                        r_term <= csvt_pkg::TERM_PEN;
                    end
                    csvt_pkg::TERM_PEN: begin
                        r_pen  <= w_pos_val[csvt_pkg::PEN_W-1:0];
                        r_term <= csvt_pkg::TERM_NET;
                    end
                    csvt_pkg::TERM_NET: begin
                        r_net  <= w_term_neg ? w_neg_val : w_pos_val;
                    end
                    default: begin
                        r_term <= csvt_pkg::TERM_RAW;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Result register: it frees the sequencer as soon as a point is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == csvt_pkg::S_OUT && w_out_go) begin
            r_o_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == csvt_pkg::S_OUT && w_out_go) begin
            r_o_time <= r_ts;
            r_o_raw  <= r_raw;
            r_o_pen  <= r_pen;
            r_o_fee  <= r_fee;
            r_o_net  <= r_net;
            r_o_dir  <= r_dir;
            r_o_buy  <= r_buy;
            r_o_sell <= r_sell;
        end
    end

    assign o_point.valid            = r_o_valid;
    assign o_point.point_time       = r_o_time;
    assign o_point.raw_spread       = $signed(r_o_raw);
    assign o_point.internal_penalty = r_o_pen;
    assign o_point.fee_out          = $signed(r_o_fee);
    assign o_point.net_spread       = $signed(r_o_net);
    assign o_point.direction        = r_o_dir;
    assign o_point.buy_price        = csvt_pkg::PRICE_F_W'(r_o_buy);
    assign o_point.sell_price       = csvt_pkg::PRICE_F_W'(r_o_sell);

endmodule
